// ===== design/lptc_pkg.sv =====
// lptc_pkg: shared types and codes for the link power tier controller
// no dependencies; imported by every module of the block

package lptc_pkg;

  localparam int unsigned CFG_DATA_W = 22;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned RETRY_W    = 17;

  // event codes carried in func
  typedef enum logic [2:0] {
    FN_TICK       = 3'd0,
    FN_ACTIVE     = 3'd1,
    FN_IDLE       = 3'd2,
    FN_SLEEP      = 3'd3,
    FN_SUBRATE    = 3'd4,
    FN_RATE_CHG   = 3'd5,
    FN_SECURED    = 3'd6,
    FN_DISCONNECT = 3'd7
  } lptc_func_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IDLE_DELAY    = 3'd0,
    REG_DORMANT_DELAY = 3'd1,
    REG_RETRY_BASE    = 3'd2,
    REG_MAX_RETRIES   = 3'd3,
    REG_ACTIVE_FACTOR = 3'd4,
    REG_IDLE_FACTOR   = 3'd5,
    REG_DORM_FACTOR   = 3'd6,
    REG_UNUSED        = 3'd7
  } lptc_reg_e;

  localparam logic [1:0] PT_ACTIVE  = 2'd0;
  localparam logic [1:0] PT_IDLE    = 2'd1;
  localparam logic [1:0] PT_DORMANT = 2'd2;

  localparam logic [1:0] ST_SUCCESS     = 2'd0;
  localparam logic [1:0] ST_UNSUPPORTED = 2'd1;

  localparam int unsigned IDLE_DELAY_RST    = 10000;
  localparam int unsigned DORMANT_DELAY_RST = 60000;
  localparam logic [9:0]  RETRY_BASE_RST    = 10'd20;
  localparam logic [3:0]  MAX_RETRIES_RST   = 4'd6;
  localparam logic [8:0]  ACTIVE_FACTOR_RST = 9'd1;
  localparam logic [8:0]  IDLE_FACTOR_RST   = 9'd4;
  localparam logic [8:0]  DORM_FACTOR_RST   = 9'd16;

  typedef struct packed {
    lptc_func_e func;
    logic       is_central;
    logic [1:0] status;
    logic [8:0] reported_factor;
  } lptc_item_t;

  typedef struct packed {
    logic       request_issued;
    logic [1:0] tier;
    logic       confirmed;
    logic [3:0] attempts;
    logic       gave_up;
  } lptc_result_t;

  // fixed-width configuration fields
  typedef struct packed {
    logic [9:0] retry_base;
    logic [3:0] max_retries;
    logic [8:0] active_factor;
    logic [8:0] idle_factor;
    logic [8:0] dormant_factor;
  } lptc_cfg_t;

endpackage

// ===== design/lptc_cfg_regs.sv =====
// lptc_cfg_regs: configuration register file written through the cfg channel
// depends on lptc_pkg

module lptc_cfg_regs #(
  parameter int unsigned DELAY_BITS = 22
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               wr_en_i,
  input  logic [lptc_pkg::CFG_IDX_W-1:0]     wr_idx_i,
  input  logic [lptc_pkg::CFG_DATA_W-1:0]    wr_data_i,
  output logic [DELAY_BITS-1:0]              idle_delay_o,
  output logic [DELAY_BITS-1:0]              dormant_delay_o,
  output lptc_pkg::lptc_cfg_t                cfg_o
);
  import lptc_pkg::*;

  localparam logic [DELAY_BITS-1:0] IdleRst    = DELAY_BITS'(IDLE_DELAY_RST);
  localparam logic [DELAY_BITS-1:0] DormantRst = DELAY_BITS'(DORMANT_DELAY_RST);

  logic [DELAY_BITS-1:0] idle_delay_q, dormant_delay_q;
  lptc_cfg_t             cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_delay_q         <= IdleRst;
      dormant_delay_q      <= DormantRst;
      cfg_q.retry_base     <= RETRY_BASE_RST;
      cfg_q.max_retries    <= MAX_RETRIES_RST;
      cfg_q.active_factor  <= ACTIVE_FACTOR_RST;
      cfg_q.idle_factor    <= IDLE_FACTOR_RST;
      cfg_q.dormant_factor <= DORM_FACTOR_RST;
    end else if (wr_en_i) begin
      unique case (lptc_reg_e'(wr_idx_i))
        REG_IDLE_DELAY:    idle_delay_q         <= DELAY_BITS'(wr_data_i);
        REG_DORMANT_DELAY: dormant_delay_q      <= DELAY_BITS'(wr_data_i);
        REG_RETRY_BASE:    cfg_q.retry_base     <= wr_data_i[9:0];
        REG_MAX_RETRIES:   cfg_q.max_retries    <= wr_data_i[3:0];
        REG_ACTIVE_FACTOR: cfg_q.active_factor  <= wr_data_i[8:0];
        REG_IDLE_FACTOR:   cfg_q.idle_factor    <= wr_data_i[8:0];
        REG_DORM_FACTOR:   cfg_q.dormant_factor <= wr_data_i[8:0];
        default: ;
      endcase
    end
  end

  assign idle_delay_o    = idle_delay_q;
  assign dormant_delay_o = dormant_delay_q;
  assign cfg_o           = cfg_q;

endmodule

// ===== design/lptc_timer.sv =====
// lptc_timer: one-shot millisecond countdown, next-state logic for one tick
// depends on lptc_pkg

module lptc_timer #(
  parameter int unsigned W = 22
) (
  input  logic         pend_i,
  input  logic [W-1:0] left_i,
  output logic         fire_o,
  output logic         pend_o,
  output logic [W-1:0] left_o
);
  import lptc_pkg::*;

  // a count of zero or one expires on this tick
  assign fire_o = pend_i && (left_i <= W'(1));
  assign pend_o = pend_i && !fire_o;
  assign left_o = fire_o ? '0 : (pend_i ? left_i - W'(1) : left_i);

endmodule

// ===== design/lptc_core.sv =====
// lptc_core: tier, confirmation, retry count and timer state with the step logic
// depends on lptc_pkg and lptc_timer

module lptc_core #(
  parameter int unsigned DELAY_BITS = 22
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     step_i,
  input  lptc_pkg::lptc_item_t     item_i,
  input  lptc_pkg::lptc_cfg_t      cfg_i,
  input  logic [DELAY_BITS-1:0]    idle_delay_i,
  input  logic [DELAY_BITS-1:0]    dormant_delay_i,
  output lptc_pkg::lptc_result_t   result_o
);
  import lptc_pkg::*;

  typedef struct packed {
    logic [1:0]         tier;
    logic               conf;
    logic [3:0]         cnt;
    logic               sent;
    logic               gave;
    logic               rp;
    logic [RETRY_W-1:0] rl;
    logic               rdue;
  } ctl_t;

  function automatic ctl_t do_request(input ctl_t s, input logic [1:0] t,
                                      input logic force_req, input logic [9:0] base,
                                      input logic [3:0] emax);
    ctl_t       r;
    logic [3:0] sh;
    r = s;
    if (!(t == s.tier && s.conf && !force_req)) begin
      if (t != s.tier) r.cnt = 4'd0;
      r.tier = t;
      r.conf = 1'b0;
      r.sent = 1'b1;
      sh     = (r.cnt > emax - 4'd1) ? emax - 4'd1 : r.cnt;
      r.rp   = 1'b1;
      r.rdue = 1'b0;
      r.rl   = RETRY_W'(base) << sh[2:0];
    end
    return r;
  endfunction

  function automatic ctl_t do_retry(input ctl_t s, input logic [9:0] base,
                                    input logic [3:0] emax);
    ctl_t r;
    r = s;
    if (!s.conf) begin
      r.cnt = s.cnt + 4'd1;
      if (r.cnt >= emax) begin
        r.conf = 1'b1;
        r.gave = 1'b1;
      end else begin
        r = do_request(r, r.tier, 1'b1, base, emax);
      end
    end
    return r;
  endfunction

  logic [1:0]            tier_q;
  logic                  conf_q;
  logic [3:0]            cnt_q;
  logic                  ip_q, dp_q, rp_q;
  logic [DELAY_BITS-1:0] il_q, dl_q;
  logic [RETRY_W-1:0]    rl_q;

  logic                  ip_d, dp_d;
  logic [DELAY_BITS-1:0] il_d, dl_d;
  ctl_t                  ctl;

  logic                  i_fire, d_fire, r_fire;
  logic                  i_pend, d_pend, r_pend;
  logic [DELAY_BITS-1:0] i_left, d_left;
  logic [RETRY_W-1:0]    r_left;
  logic [3:0]            emax;
  logic [8:0]            tier_factor;

  lptc_timer #(.W(DELAY_BITS)) u_idle_tmr (
    .pend_i(ip_q), .left_i(il_q), .fire_o(i_fire), .pend_o(i_pend), .left_o(i_left)
  );
  lptc_timer #(.W(DELAY_BITS)) u_dorm_tmr (
    .pend_i(dp_q), .left_i(dl_q), .fire_o(d_fire), .pend_o(d_pend), .left_o(d_left)
  );
  lptc_timer #(.W(RETRY_W)) u_retry_tmr (
    .pend_i(rp_q), .left_i(rl_q), .fire_o(r_fire), .pend_o(r_pend), .left_o(r_left)
  );

  // max retries clamped into 1..8
  assign emax = (cfg_i.max_retries == 4'd0) ? 4'd1 :
                (cfg_i.max_retries > 4'd8)  ? 4'd8 : cfg_i.max_retries;

  always_comb begin
    unique case (tier_q)
      PT_ACTIVE: tier_factor = cfg_i.active_factor;
      PT_IDLE:   tier_factor = cfg_i.idle_factor;
      default:   tier_factor = cfg_i.dormant_factor;
    endcase
  end

  always_comb begin
    logic d_due;
    ctl  = '{tier: tier_q, conf: conf_q, cnt: cnt_q, sent: 1'b0, gave: 1'b0,
             rp: rp_q, rl: rl_q, rdue: 1'b0};
    ip_d = ip_q;
    il_d = il_q;
    dp_d = dp_q;
    dl_d = dl_q;
    d_due = 1'b0;
    unique case (item_i.func)
      FN_TICK: begin
        ip_d     = i_pend;
        il_d     = i_left;
        dp_d     = d_pend;
        dl_d     = d_left;
        d_due    = d_fire;
        ctl.rp   = r_pend;
        ctl.rl   = r_left;
        ctl.rdue = r_fire;
        // handlers run idle, dormant, retry; earlier ones may cancel later ones
        if (i_fire) begin
          d_due = 1'b0;
          ctl   = do_request(ctl, PT_IDLE, 1'b0, cfg_i.retry_base, emax);
          dp_d  = 1'b1;
          dl_d  = dormant_delay_i;
        end
        if (d_due) begin
          ctl = do_request(ctl, PT_DORMANT, 1'b0, cfg_i.retry_base, emax);
        end
        if (ctl.rdue) begin
          ctl = do_retry(ctl, cfg_i.retry_base, emax);
        end
      end
      FN_ACTIVE, FN_SLEEP: begin
        ip_d = 1'b0;
        il_d = '0;
        dp_d = 1'b0;
        dl_d = '0;
        ctl  = do_request(ctl, (item_i.func == FN_ACTIVE) ? PT_ACTIVE : PT_DORMANT,
                          1'b0, cfg_i.retry_base, emax);
      end
      FN_IDLE: begin
        if (idle_delay_i == '0) begin
          ctl  = do_request(ctl, PT_IDLE, 1'b0, cfg_i.retry_base, emax);
          dp_d = 1'b1;
          dl_d = dormant_delay_i;
        end else begin
          dp_d = 1'b0;
          dl_d = '0;
          // a pending idle timer keeps its count
          if (!ip_q) begin
            ip_d = 1'b1;
            il_d = idle_delay_i;
          end
        end
      end
      FN_SUBRATE: begin
        if (item_i.is_central && item_i.status <= ST_UNSUPPORTED) begin
          ctl.conf = 1'b1;
          ctl.cnt  = 4'd0;
          ctl.rp   = 1'b0;
          ctl.rl   = '0;
        end
      end
      FN_RATE_CHG: begin
        if (item_i.is_central && item_i.status == ST_SUCCESS &&
            item_i.reported_factor != tier_factor) begin
          ctl.cnt = 4'd0;
          ctl     = do_request(ctl, ctl.tier, 1'b1, cfg_i.retry_base, emax);
        end
      end
      FN_SECURED: begin
        if (item_i.is_central && item_i.status == ST_SUCCESS && tier_q != PT_ACTIVE) begin
          ctl.cnt = 4'd0;
          ctl     = do_request(ctl, ctl.tier, 1'b1, cfg_i.retry_base, emax);
        end
      end
      FN_DISCONNECT: begin
        if (item_i.is_central) begin
          ctl.rp   = 1'b0;
          ctl.rl   = '0;
          ctl.conf = 1'b1;
          ctl.cnt  = 4'd0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tier_q <= PT_ACTIVE;
      conf_q <= 1'b1;
      cnt_q  <= 4'd0;
      ip_q   <= 1'b0;
      il_q   <= '0;
      dp_q   <= 1'b0;
      dl_q   <= '0;
      rp_q   <= 1'b0;
      rl_q   <= '0;
    end else if (step_i) begin
      tier_q <= ctl.tier;
      conf_q <= ctl.conf;
      cnt_q  <= ctl.cnt;
      ip_q   <= ip_d;
      il_q   <= il_d;
      dp_q   <= dp_d;
      dl_q   <= dl_d;
      rp_q   <= ctl.rp;
      rl_q   <= ctl.rl;
    end
  end

  assign result_o = '{request_issued: ctl.sent, tier: ctl.tier, confirmed: ctl.conf,
                      attempts: ctl.cnt, gave_up: ctl.gave};

endmodule

// ===== design/link_power_tier_controller_top.sv =====
// link_power_tier_controller_top: input register, step core and result register
// depends on lptc_pkg, lptc_cfg_regs and lptc_core
//
//   channel  direction  handshake              payload
//   in       sink       in_valid_i/in_ready_o  func_i is_central_i status_i reported_factor_i
//   out      source     out_valid_o/out_ready_i request_issued_o tier_o confirmed_o
//                                              attempts_o gave_up_o
//   cfg      sink       cfg_valid_i/cfg_ready_o cfg_index_i cfg_wdata_i
//
// one transaction per cycle sustained while the output is not stalled; a taken input waits in
// the input register, passes the combinational step logic and lands in the result register
// reset loads the register defaults, active tier, confirmed, all timers idle
// a stalled output holds the result register, then the input register, then
// drops in_ready_o; cfg_ready_o is always high

module link_power_tier_controller_top #(
  parameter int unsigned DELAY_BITS = 22
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [2:0]                      func_i,
  input  logic                            is_central_i,
  input  logic [1:0]                      status_i,
  input  logic [8:0]                      reported_factor_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            request_issued_o,
  output logic [1:0]                      tier_o,
  output logic                            confirmed_o,
  output logic [3:0]                      attempts_o,
  output logic                            gave_up_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [lptc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [lptc_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import lptc_pkg::*;

  logic                  in_valid_q, in_valid_d;
  lptc_item_t            item_q;
  logic                  out_valid_q, out_valid_d;
  lptc_result_t          res_q, res_d;
  logic                  step;
  logic [DELAY_BITS-1:0] idle_delay, dormant_delay;
  lptc_cfg_t             cfg;

  assign cfg_ready_o = 1'b1;

  lptc_cfg_regs #(.DELAY_BITS(DELAY_BITS)) u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .wr_en_i        (cfg_valid_i && cfg_ready_o),
    .wr_idx_i       (cfg_index_i),
    .wr_data_i      (cfg_wdata_i),
    .idle_delay_o   (idle_delay),
    .dormant_delay_o(dormant_delay),
    .cfg_o          (cfg)
  );

  // the held item steps when the result register is free or being drained
  assign step       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step;

  lptc_core #(.DELAY_BITS(DELAY_BITS)) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .item_i         (item_q),
    .cfg_i          (cfg),
    .idle_delay_i   (idle_delay),
    .dormant_delay_i(dormant_delay),
    .result_o       (res_d)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_valid_i && in_ready_o) in_valid_d = 1'b1;
    else if (step)                in_valid_d = 1'b0;
    out_valid_d = out_valid_q;
    if (step)             out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= '{func: lptc_func_e'(func_i), is_central: is_central_i,
                  status: status_i, reported_factor: reported_factor_i};
    end
    if (step) res_q <= res_d;
  end

  assign out_valid_o      = out_valid_q;
  assign request_issued_o = res_q.request_issued;
  assign tier_o           = res_q.tier;
  assign confirmed_o      = res_q.confirmed;
  assign attempts_o       = res_q.attempts;
  assign gave_up_o        = res_q.gave_up;

`ifndef SYNTHESIS
  a_gave_up_settles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && gave_up_o |-> confirmed_o)
    else $error("gave up without settling the tier");

  a_request_unconfirmed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && request_issued_o |-> !confirmed_o)
    else $error("tier request left the tier confirmed");

  a_backpressure_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> in_valid_q && out_valid_o && !out_ready_i)
    else $error("input stalled while the result register could move");

  a_step_loads_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_o)
    else $error("stepped item produced no result");
`endif

endmodule

// ===== sim/lptc_tier_checker.sv =====
`timescale 1ns / 1ps
// lptc_tier_checker: watches the event, result and register channels of the power
// tier controller, tracks tier, retry count and timers itself and compares results
// depends on lptc_pkg

module lptc_tier_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  logic [2:0]                      func_i,
  input  logic                            is_central_i,
  input  logic [1:0]                      status_i,
  input  logic [8:0]                      reported_factor_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  logic                            request_issued_i,
  input  logic [1:0]                      tier_i,
  input  logic                            confirmed_i,
  input  logic [3:0]                      attempts_i,
  input  logic                            gave_up_i,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [lptc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [lptc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output int                              faults_o,
  output int                              outstanding_o
);
  import lptc_pkg::*;

  // register copies
  logic [CFG_DATA_W-1:0] idle_dly_q, dorm_dly_q;
  logic [9:0]            base_q;
  logic [3:0]            max_q;
  logic [8:0]            f_act_q, f_idle_q, f_dorm_q;

  // tier state and one-shot timers
  logic [1:0]            tier_q;
  logic                  settled_q;
  logic [3:0]            tries_q;
  logic [CFG_DATA_W-1:0] idle_left, dorm_left;
  logic [RETRY_W-1:0]    retry_left;
  logic                  idle_arm, dorm_arm, retry_arm;
  logic                  idle_due, dorm_due, retry_due;
  logic                  sent_now, gave_up_now;

  lptc_result_t tier_outcomes_due[$];
  int faults = 0;

  assign faults_o = faults;

  function automatic logic [3:0] retry_cap();
    if (max_q == 4'd0) return 4'd1;
    if (max_q > 4'd8) return 4'd8;
    return max_q;
  endfunction

  function automatic void drop_idle();
    idle_arm = 1'b0;
    idle_due = 1'b0;
    idle_left = '0;
  endfunction

  function automatic void drop_dormant();
    dorm_arm = 1'b0;
    dorm_due = 1'b0;
    dorm_left = '0;
  endfunction

  function automatic void drop_retry();
    retry_arm = 1'b0;
    retry_due = 1'b0;
    retry_left = '0;
  endfunction

  function automatic logic [8:0] tier_factor(input logic [1:0] t);
    if (t == PT_ACTIVE) return f_act_q;
    if (t == PT_IDLE) return f_idle_q;
    return f_dorm_q;
  endfunction

  // send a tier request and arm the backoff of base << min(count, max-1)
  function automatic void ask_tier(input logic [1:0] t, input logic again);
    logic [3:0] sh;
    if (t == tier_q && settled_q && !again) return;
    if (t != tier_q) tries_q = '0;
    tier_q = t;
    settled_q = 1'b0;
    sent_now = 1'b1;
    sh = tries_q;
    if (sh > retry_cap() - 4'd1) sh = retry_cap() - 4'd1;
    retry_arm = 1'b1;
    retry_due = 1'b0;
    retry_left = {7'd0, base_q} << sh;
  endfunction

  function automatic void go_idle();
    drop_dormant();
    ask_tier(PT_IDLE, 1'b0);
    dorm_arm = 1'b1;
    dorm_left = dorm_dly_q;
  endfunction

  function automatic void retry_expired();
    if (settled_q) return;
    tries_q = tries_q + 4'd1;
    if (tries_q >= retry_cap()) begin
      settled_q = 1'b1;
      gave_up_now = 1'b1;
      return;
    end
    ask_tier(tier_q, 1'b1);
  endfunction

  function automatic lptc_result_t next_tier_outcome(input lptc_item_t ev);
    lptc_result_t r;
    sent_now = 1'b0;
    gave_up_now = 1'b0;
    case (ev.func)
      FN_TICK: begin
        // a timer that is not armed sits at zero, so counting it is harmless
        idle_due = idle_arm && idle_left <= 1;
        dorm_due = dorm_arm && dorm_left <= 1;
        retry_due = retry_arm && retry_left <= 1;
        if (idle_due) idle_arm = 1'b0;
        if (dorm_due) dorm_arm = 1'b0;
        if (retry_due) retry_arm = 1'b0;
        idle_left = (idle_left <= 1) ? '0 : idle_left - 1'b1;
        dorm_left = (dorm_left <= 1) ? '0 : dorm_left - 1'b1;
        retry_left = (retry_left <= 1) ? '0 : retry_left - 1'b1;
        // handlers may cancel or re-arm a later timer before it runs
        if (idle_due) begin
          idle_due = 1'b0;
          go_idle();
        end
        if (dorm_due) begin
          dorm_due = 1'b0;
          ask_tier(PT_DORMANT, 1'b0);
        end
        if (retry_due) begin
          retry_due = 1'b0;
          retry_expired();
        end
      end
      FN_ACTIVE: begin
        drop_idle();
        drop_dormant();
        ask_tier(PT_ACTIVE, 1'b0);
      end
      FN_IDLE: begin
        if (idle_dly_q == '0) begin
          go_idle();
        end else begin
          drop_dormant();
          if (!idle_arm) begin
            idle_arm = 1'b1;
            idle_left = idle_dly_q;
          end
        end
      end
      FN_SLEEP: begin
        drop_idle();
        drop_dormant();
        ask_tier(PT_DORMANT, 1'b0);
      end
      FN_SUBRATE: begin
        if (ev.is_central && ev.status <= ST_UNSUPPORTED) begin
          settled_q = 1'b1;
          tries_q = '0;
          drop_retry();
        end
      end
      FN_RATE_CHG: begin
        if (ev.is_central && ev.status == ST_SUCCESS &&
            ev.reported_factor != tier_factor(tier_q)) begin
          tries_q = '0;
          ask_tier(tier_q, 1'b1);
        end
      end
      FN_SECURED: begin
        if (ev.is_central && ev.status == ST_SUCCESS && tier_q != PT_ACTIVE) begin
          tries_q = '0;
          ask_tier(tier_q, 1'b1);
        end
      end
      FN_DISCONNECT: begin
        if (ev.is_central) begin
          drop_retry();
          settled_q = 1'b1;
          tries_q = '0;
        end
      end
      default: ;
    endcase
    r.request_issued = sent_now;
    r.tier = tier_q;
    r.confirmed = settled_q;
    r.attempts = tries_q;
    r.gave_up = gave_up_now;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    lptc_item_t   ev;
    lptc_result_t seen, want;
    if (!rst_ni) begin
      idle_dly_q = IDLE_DELAY_RST;
      dorm_dly_q = DORMANT_DELAY_RST;
      base_q = RETRY_BASE_RST;
      max_q = MAX_RETRIES_RST;
      f_act_q = ACTIVE_FACTOR_RST;
      f_idle_q = IDLE_FACTOR_RST;
      f_dorm_q = DORM_FACTOR_RST;
      tier_q = PT_ACTIVE;
      settled_q = 1'b1;
      tries_q = '0;
      drop_idle();
      drop_dormant();
      drop_retry();
      tier_outcomes_due.delete();
      outstanding_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (lptc_reg_e'(cfg_index_i))
          REG_IDLE_DELAY:    idle_dly_q = cfg_wdata_i;
          REG_DORMANT_DELAY: dorm_dly_q = cfg_wdata_i;
          REG_RETRY_BASE:    base_q = cfg_wdata_i[9:0];
          REG_MAX_RETRIES:   max_q = cfg_wdata_i[3:0];
          REG_ACTIVE_FACTOR: f_act_q = cfg_wdata_i[8:0];
          REG_IDLE_FACTOR:   f_idle_q = cfg_wdata_i[8:0];
          REG_DORM_FACTOR:   f_dorm_q = cfg_wdata_i[8:0];
          default: ;
        endcase
      end
      // results leave before the same-edge transaction is predicted
      if (out_valid_i && out_ready_i) begin
        seen = {request_issued_i, tier_i, confirmed_i, attempts_i, gave_up_i};
        if (tier_outcomes_due.size() == 0) begin
          faults++;
          if (faults <= 10)
            $display("%0t: tier result with nothing outstanding: ", $realtime,
                     "req=%0d tier=%0d conf=%0d att=%0d gave_up=%0d",
                     seen.request_issued, seen.tier, seen.confirmed,
                     seen.attempts, seen.gave_up);
        end else begin
          want = tier_outcomes_due.pop_front();
          if (seen != want) begin
            faults++;
            if (faults <= 10)
              $display("%0t: tier result mismatch: ", $realtime,
                       "want req=%0d tier=%0d conf=%0d att=%0d gave_up=%0d, ",
                       want.request_issued, want.tier, want.confirmed,
                       want.attempts, want.gave_up,
                       "got req=%0d tier=%0d conf=%0d att=%0d gave_up=%0d",
                       seen.request_issued, seen.tier, seen.confirmed,
                       seen.attempts, seen.gave_up);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        ev = {func_i, is_central_i, status_i, reported_factor_i};
        tier_outcomes_due.push_back(next_tier_outcome(ev));
      end
      outstanding_o <= tier_outcomes_due.size();
    end
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// tb: drives link events, ticks and register writes into the power tier controller
// depends on lptc_pkg, link_power_tier_controller_top and lptc_tier_checker

module tb;
  import lptc_pkg::*;

  localparam logic [1:0] ST_OTHER_FAIL = 2'd2;
  localparam logic [1:0] ST_RESERVED   = 2'd3;
  localparam int         PHASES        = 10;
  localparam int         PHASE_EVENTS  = 190;

  logic                  clk_i, rst_ni;
  logic                  in_valid_i, in_ready_o;
  logic [2:0]            func_i;
  logic                  is_central_i;
  logic [1:0]            status_i;
  logic [8:0]            reported_factor_i;
  logic                  out_valid_o, out_ready_i;
  logic                  request_issued_o;
  logic [1:0]            tier_o;
  logic                  confirmed_o;
  logic [3:0]            attempts_o;
  logic                  gave_up_o;
  logic                  cfg_valid_i, cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  int         faults, outstanding;
  bit         gaps_on = 1'b1;
  int         squeeze_asks = 0;
  logic [8:0] fac_act = ACTIVE_FACTOR_RST;
  logic [8:0] fac_idle = IDLE_FACTOR_RST;
  logic [8:0] fac_dorm = DORM_FACTOR_RST;

  link_power_tier_controller_top dut (.*);

  lptc_tier_checker chk (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_i       (in_ready_o),
    .func_i,
    .is_central_i,
    .status_i,
    .reported_factor_i,
    .out_valid_i      (out_valid_o),
    .out_ready_i,
    .request_issued_i (request_issued_o),
    .tier_i           (tier_o),
    .confirmed_i      (confirmed_o),
    .attempts_i       (attempts_o),
    .gave_up_i        (gave_up_o),
    .cfg_valid_i,
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i,
    .cfg_wdata_i,
    .faults_o         (faults),
    .outstanding_o    (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // result side: random stalls, plus a long hold-off whenever the stimulus asks
  initial begin : drain
    int hold, squeeze_seen;
    hold = 0;
    squeeze_seen = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold > 0) begin
        hold--;
        out_ready_i <= 1'b0;
      end else if (squeeze_seen != squeeze_asks) begin
        squeeze_seen = squeeze_asks;
        hold = 80;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= !(gaps_on && $urandom_range(99) < 26);
      end
    end
  end

  function automatic lptc_item_t link_event(input lptc_func_e f, input logic c,
                                            input logic [1:0] s, input logic [8:0] fac);
    lptc_item_t ev;
    ev.func = f;
    ev.is_central = c;
    ev.status = s;
    ev.reported_factor = fac;
    return ev;
  endfunction

  // mostly ticks and activity, link events with mostly central links and good status
  function automatic lptc_item_t pick_event();
    lptc_item_t ev;
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 48)      ev.func = FN_TICK;
    else if (roll < 60) ev.func = FN_IDLE;
    else if (roll < 68) ev.func = FN_ACTIVE;
    else if (roll < 74) ev.func = FN_SLEEP;
    else if (roll < 82) ev.func = FN_SUBRATE;
    else if (roll < 88) ev.func = FN_RATE_CHG;
    else if (roll < 94) ev.func = FN_SECURED;
    else                ev.func = FN_DISCONNECT;
    ev.is_central = ($urandom_range(99) < 85);
    roll = $urandom_range(99);
    if (roll < 60)      ev.status = ST_SUCCESS;
    else if (roll < 80) ev.status = ST_UNSUPPORTED;
    else if (roll < 95) ev.status = ST_OTHER_FAIL;
    else                ev.status = ST_RESERVED;
    case ($urandom_range(4))
      0:       ev.reported_factor = fac_act;
      1:       ev.reported_factor = fac_idle;
      2:       ev.reported_factor = fac_dorm;
      default: ev.reported_factor = 9'($urandom_range(511));
    endcase
    return ev;
  endfunction

  task automatic offer_event(input lptc_item_t ev);
    while (gaps_on && $urandom_range(99) < 26) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= ev.func;
    is_central_i <= ev.is_central;
    status_i <= ev.status;
    reported_factor_i <= ev.reported_factor;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic put_reg(input lptc_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_tier_setup(input logic [CFG_DATA_W-1:0] idle_dly, dorm_dly, base,
                                  max_tries, fa, fi, fd);
    put_reg(REG_IDLE_DELAY, idle_dly);
    put_reg(REG_DORMANT_DELAY, dorm_dly);
    put_reg(REG_RETRY_BASE, base);
    put_reg(REG_MAX_RETRIES, max_tries);
    put_reg(REG_ACTIVE_FACTOR, fa);
    put_reg(REG_IDLE_FACTOR, fi);
    put_reg(REG_DORM_FACTOR, fd);
    fac_act = fa[8:0];
    fac_idle = fi[8:0];
    fac_dorm = fd[8:0];
  endtask

  // wait until every result is back, then let the pipeline run dry
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int ph, n;
    in_valid_i = 1'b0;
    func_i = FN_TICK;
    is_central_i = 1'b0;
    status_i = ST_SUCCESS;
    reported_factor_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_IDLE_DELAY;
    cfg_wdata_i = '0;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: idle holdoff, tier requests and every link event
    offer_event(link_event(FN_TICK, 1'b1, ST_SUCCESS, 9'd1));
    offer_event(link_event(FN_IDLE, 1'b0, ST_SUCCESS, 9'd1));
    offer_event(link_event(FN_IDLE, 1'b1, ST_SUCCESS, 9'd1));
    offer_event(link_event(FN_ACTIVE, 1'b1, ST_SUCCESS, 9'd1));
    offer_event(link_event(FN_SLEEP, 1'b1, ST_SUCCESS, 9'd1));
    offer_event(link_event(FN_SUBRATE, 1'b0, ST_SUCCESS, 9'd1));
    offer_event(link_event(FN_SUBRATE, 1'b1, ST_OTHER_FAIL, 9'd1));
    offer_event(link_event(FN_SUBRATE, 1'b1, ST_UNSUPPORTED, 9'd1));
    offer_event(link_event(FN_RATE_CHG, 1'b1, ST_SUCCESS, DORM_FACTOR_RST));
    offer_event(link_event(FN_RATE_CHG, 1'b1, ST_SUCCESS, 9'd511));
    offer_event(link_event(FN_RATE_CHG, 1'b1, ST_UNSUPPORTED, 9'd3));
    offer_event(link_event(FN_SECURED, 1'b1, ST_SUCCESS, 9'd1));
    offer_event(link_event(FN_DISCONNECT, 1'b0, ST_SUCCESS, 9'd1));
    offer_event(link_event(FN_DISCONNECT, 1'b1, ST_RESERVED, 9'd1));
    offer_event(link_event(FN_ACTIVE, 1'b1, ST_SUCCESS, 9'd1));
    offer_event(link_event(FN_SECURED, 1'b1, ST_SUCCESS, 9'd1));
    offer_event(link_event(FN_RATE_CHG, 1'b1, ST_SUCCESS, 9'd0));
    settle();

    // zero idle delay, one tick to dormant, zero backoff and zero max retries
    write_tier_setup(22'd0, 22'd1, 22'd0, 22'd0, 22'd1, 22'd4, 22'd16);
    offer_event(link_event(FN_IDLE, 1'b1, ST_SUCCESS, 9'd1));
    offer_event(link_event(FN_TICK, 1'b1, ST_SUCCESS, 9'd1));
    offer_event(link_event(FN_TICK, 1'b0, ST_SUCCESS, 9'd1));
    offer_event(link_event(FN_TICK, 1'b1, ST_SUCCESS, 9'd1));
    offer_event(link_event(FN_IDLE, 1'b1, ST_SUCCESS, 9'd1));
    offer_event(link_event(FN_ACTIVE, 1'b1, ST_SUCCESS, 9'd1));
    offer_event(link_event(FN_TICK, 1'b1, ST_SUCCESS, 9'd1));
    settle();

    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: write_tier_setup(22'd0, 22'd0, 22'd1, 22'd1, 22'd1, 22'd1, 22'd1);
        1: write_tier_setup(22'h3FFFFF, 22'h3FFFFF, 22'd1000, 22'd8, 22'd500, 22'd500,
                            22'd500);
        2: begin
          // zero base and max, junk above the narrow fields, write to the spare index
          write_tier_setup(22'd3, 22'd5, {12'($urandom), 10'd0}, {18'($urandom), 4'd0},
                           {13'($urandom), 9'd0}, 22'd511, 22'd0);
          put_reg(REG_UNUSED, 22'($urandom));
        end
        3: write_tier_setup(22'h3FFFFF, 22'h3FFFFF, 22'h3FFFFF, 22'h3FFFFF, 22'h3FFFFF,
                            22'h3FFFFF, 22'h3FFFFF);
        4: write_tier_setup(22'($urandom_range(12, 2)), 22'($urandom_range(20)), 22'd1,
                            22'd15, 22'($urandom_range(500, 1)), 22'($urandom_range(500, 1)),
                            22'($urandom_range(500, 1)));
        default: write_tier_setup(22'($urandom_range(12)), 22'($urandom_range(20)),
                                  22'($urandom_range(4, 1)), 22'($urandom_range(8, 1)),
                                  22'($urandom_range(500, 1)), 22'($urandom_range(500, 1)),
                                  22'($urandom_range(500, 1)));
      endcase
      gaps_on = (ph != 5);
      for (n = 0; n < PHASE_EVENTS; n++) begin
        if ((ph == 4 || ph == 7) && n == 60) squeeze_asks++;
        offer_event(pick_event());
      end
      settle();
    end

    if (faults == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/lptc_pkg.sv
design/lptc_cfg_regs.sv
design/lptc_timer.sv
design/lptc_core.sv
design/link_power_tier_controller_top.sv
sim/lptc_tier_checker.sv
sim/tb.sv
